// File: sv/ecpa_pkg.sv
// shared types and constants for the elliptic-curve point unit
// no dependencies
package ecpa_pkg;

    localparam int FIELD_BITS_DEF  = 16;
    localparam int SCALAR_BITS_DEF = 16;
    localparam int FP_RESET        = 65521;
    localparam int CFG_IDX_BITS    = 2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_FIELD_PRIME = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CURVE_A     = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CURVE_B     = 2'd2;

    localparam logic REQ_ADD = 1'b0;
    localparam logic REQ_MUL = 1'b1;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_ctrl_t;

    typedef enum logic [5:0] {
        S_IDLE,
        S_RED_PX, S_RED_PY, S_RED_QX, S_RED_QY, S_RED_A, S_RED_B,
        S_ONC_LHS, S_ONC_X2, S_ONC_X3, S_ONC_AX, S_ONC_S1, S_ONC_S2,
        S_DISPATCH, S_TOP, S_MUL_NEXT,
        S_PA_CHK, S_PA_NEG, S_PA_END,
        S_DB_X2, S_DB_M3, S_DB_PA, S_DB_Y2,
        S_AD_DY, S_AD_DX,
        S_INV_INIT, S_INV_CHK, S_INV_DIV, S_INV_MUL, S_INV_SUB,
        S_SLOPE, S_X_SS, S_X_S1, S_X_S2, S_Y_D, S_Y_M, S_Y_S,
        S_DONE
    } seq_state_t;

endpackage

// File: sv/ecpa_alu.sv
// shared modular arithmetic unit: add, subtract, shift-add multiply, restoring divide
// depends on ecpa_pkg
module ecpa_alu import ecpa_pkg::*; #(
    parameter int FB = FIELD_BITS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  alu_ctrl_t     ctrl,
    input  logic [FB-1:0] op_a,
    input  logic [FB-1:0] op_b,
    input  logic [FB-1:0] modulus,
    output logic [FB-1:0] res,
    output logic [FB-1:0] quo,
    output logic          done
);

    localparam int CW = $clog2(FB + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    alu_op_t       op_reg, op_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [FB:0]   acc_reg, acc_next;
    logic [FB-1:0] sh_reg, sh_next;
    logic [FB-1:0] opd_reg, opd_next;
    logic [FB-1:0] m_reg, m_next;

    logic [FB:0] sum, dif, dbl, dbl_r, mac, mac_r, rem2;

    always_comb begin
        sum   = {1'b0, op_a} + {1'b0, op_b};
        dif   = (op_a >= op_b) ? {1'b0, op_a - op_b}
                               : {1'b0, op_a} + {1'b0, modulus} - {1'b0, op_b};
        dbl   = {acc_reg[FB-1:0], 1'b0};
        dbl_r = (dbl >= {1'b0, m_reg}) ? dbl - {1'b0, m_reg} : dbl;
        mac   = dbl_r + {1'b0, opd_reg};
        mac_r = (mac >= {1'b0, m_reg}) ? mac - {1'b0, m_reg} : mac;
        rem2  = {acc_reg[FB-1:0], sh_reg[FB-1]};
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        sh_next   = sh_reg;
        opd_next  = opd_reg;
        m_next    = m_reg;
        if (ctrl.start) begin
            op_next = ctrl.op;
            m_next  = modulus;
            case (ctrl.op)
                ALU_ADD: begin
                    acc_next  = (sum >= {1'b0, modulus}) ? sum - {1'b0, modulus} : sum;
                    done_next = 1'b1;
                end
                ALU_SUB: begin
                    acc_next  = dif;
                    done_next = 1'b1;
                end
                ALU_MUL: begin
                    acc_next  = '0;
                    sh_next   = op_b;
                    opd_next  = op_a;
                    cnt_next  = CW'(FB);
                    busy_next = 1'b1;
                end
                default: begin
                    acc_next  = '0;
                    sh_next   = op_a;
                    opd_next  = op_b;
                    cnt_next  = CW'(FB);
                    busy_next = 1'b1;
                end
            endcase
        end else if (busy_reg) begin
            if (op_reg == ALU_MUL) begin
                acc_next = sh_reg[FB-1] ? mac_r : dbl_r;
                sh_next  = {sh_reg[FB-2:0], 1'b0};
            end else begin
                if (rem2 >= {1'b0, opd_reg}) begin
                    acc_next = rem2 - {1'b0, opd_reg};
                    sh_next  = {sh_reg[FB-2:0], 1'b1};
                end else begin
                    acc_next = rem2;
                    sh_next  = {sh_reg[FB-2:0], 1'b0};
                end
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= ALU_ADD;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
        acc_reg <= acc_next;
        sh_reg  <= sh_next;
        opd_reg <= opd_next;
        m_reg   <= m_next;
    end

    assign res  = acc_reg[FB-1:0];
    assign quo  = sh_reg;
    assign done = done_reg;

endmodule

// File: sv/ec_point_add_and_scalar_multiply.sv
// top level: configuration registers, point-operation sequencer, output register
// depends on ecpa_pkg and ecpa_alu
//
//  channel  direction  handshake            payload
//  s_       in         s_valid / s_ready    req_type, p, q, scalar_k
//  m_       out        m_valid / m_ready    r, r_is_infinity, p_on_curve, inverse_failed
//  cfg_     in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one item at a time; s_ready is high only while the sequencer is idle
// every field op goes through the one alu
// an inversion runs euclid steps until the remainder is zero, and the euclid
// step count sets the length of a point op; a k*P item is up to
// 2*(SCALAR_BITS-1) point ops
// the result sits in an output register; a stalled m_ready holds the next result
// synchronous active-low reset sets control state and the config registers; datapath is not reset
module ec_point_add_and_scalar_multiply import ecpa_pkg::*; #(
    parameter int FIELD_BITS  = FIELD_BITS_DEF,
    parameter int SCALAR_BITS = SCALAR_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_req_type,
    input  logic [FIELD_BITS-1:0]   s_p_x,
    input  logic [FIELD_BITS-1:0]   s_p_y,
    input  logic                    s_p_is_infinity,
    input  logic [FIELD_BITS-1:0]   s_q_x,
    input  logic [FIELD_BITS-1:0]   s_q_y,
    input  logic                    s_q_is_infinity,
    input  logic [SCALAR_BITS-1:0]  s_scalar_k,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [FIELD_BITS-1:0]   m_r_x,
    output logic [FIELD_BITS-1:0]   m_r_y,
    output logic                    m_r_is_infinity,
    output logic                    m_p_on_curve,
    output logic                    m_inverse_failed,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [FIELD_BITS-1:0]   cfg_data
);

    localparam int FB = FIELD_BITS;
    localparam int SB = SCALAR_BITS;
    localparam int CW = $clog2(SB);

    typedef struct packed {
        logic [FB-1:0] px, py, qx, qy, ar, br;
        logic [FB-1:0] rx, ry, ax, ay, s, t0, t1, t2;
        logic [FB-1:0] r0, r1, v0, v1, qq, rm;
        logic          rinf, ainf, pinf, qinf;
        logic          is_mul, onc, bad, dbl;
        logic [SB-1:0] k;
        logic [CW-1:0] cnt;
    } dp_t;

    seq_state_t    state_reg, state_next;
    dp_t           dp_reg, dp_next;
    logic          issued_reg, issued_next;
    logic [FB-1:0] fp_reg, ca_reg, cb_reg;

    logic          m_valid_reg, m_valid_next;
    logic [FB-1:0] m_r_x_reg, m_r_y_reg;
    logic          m_r_inf_reg, m_onc_reg, m_bad_reg;

    alu_ctrl_t     alu_ctrl;
    logic          use_alu;
    alu_op_t       alu_op;
    logic [FB-1:0] alu_a, alu_b, alu_res, alu_quo;
    logic          alu_done;

    logic s_acc, out_load, fp_low;

    assign s_ready   = (state_reg == S_IDLE);
    assign s_acc     = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign fp_low    = (fp_reg < FB'(2));
    assign out_load  = (state_reg == S_DONE) && (!m_valid_reg || m_ready);

    ecpa_alu #(.FB(FB)) u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (alu_ctrl),
        .op_a    (alu_a),
        .op_b    (alu_b),
        .modulus (fp_reg),
        .res     (alu_res),
        .quo     (alu_quo),
        .done    (alu_done)
    );

    // operand selection per state
    always_comb begin
        use_alu = 1'b1;
        alu_op  = ALU_MUL;
        alu_a   = '0;
        alu_b   = '0;
        case (state_reg)
            S_RED_PX:  begin alu_op = ALU_DIV; alu_a = dp_reg.px; alu_b = fp_reg; end
            S_RED_PY:  begin alu_op = ALU_DIV; alu_a = dp_reg.py; alu_b = fp_reg; end
            S_RED_QX:  begin alu_op = ALU_DIV; alu_a = dp_reg.qx; alu_b = fp_reg; end
            S_RED_QY:  begin alu_op = ALU_DIV; alu_a = dp_reg.qy; alu_b = fp_reg; end
            S_RED_A:   begin alu_op = ALU_DIV; alu_a = ca_reg; alu_b = fp_reg; end
            S_RED_B:   begin alu_op = ALU_DIV; alu_a = cb_reg; alu_b = fp_reg; end
            S_ONC_LHS: begin alu_a = dp_reg.py; alu_b = dp_reg.py; end
            S_ONC_X2:  begin alu_a = dp_reg.px; alu_b = dp_reg.px; end
            S_ONC_X3:  begin alu_a = dp_reg.t1; alu_b = dp_reg.px; end
            S_ONC_AX:  begin alu_a = dp_reg.ar; alu_b = dp_reg.px; end
            S_ONC_S1:  begin alu_op = ALU_ADD; alu_a = dp_reg.t1; alu_b = dp_reg.t2; end
            S_ONC_S2:  begin alu_op = ALU_ADD; alu_a = dp_reg.t1; alu_b = dp_reg.br; end
            S_PA_NEG:  begin alu_op = ALU_SUB; alu_a = '0; alu_b = dp_reg.ay; end
            S_DB_X2:   begin alu_a = dp_reg.rx; alu_b = dp_reg.rx; end
            S_DB_M3:   begin alu_a = dp_reg.t1; alu_b = FB'(3); end
            S_DB_PA:   begin alu_op = ALU_ADD; alu_a = dp_reg.t1; alu_b = dp_reg.ar; end
            S_DB_Y2:   begin alu_op = ALU_ADD; alu_a = dp_reg.ry; alu_b = dp_reg.ry; end
            S_AD_DY:   begin alu_op = ALU_SUB; alu_a = dp_reg.ry; alu_b = dp_reg.ay; end
            S_AD_DX:   begin alu_op = ALU_SUB; alu_a = dp_reg.rx; alu_b = dp_reg.ax; end
            S_INV_DIV: begin alu_op = ALU_DIV; alu_a = dp_reg.r0; alu_b = dp_reg.r1; end
            S_INV_MUL: begin alu_a = dp_reg.v1; alu_b = dp_reg.qq; end
            S_INV_SUB: begin alu_op = ALU_SUB; alu_a = dp_reg.v0; alu_b = dp_reg.t0; end
            S_SLOPE:   begin alu_a = dp_reg.t1; alu_b = dp_reg.t2; end
            S_X_SS:    begin alu_a = dp_reg.s; alu_b = dp_reg.s; end
            S_X_S1:    begin alu_op = ALU_SUB; alu_a = dp_reg.t0; alu_b = dp_reg.rx; end
            S_X_S2:    begin alu_op = ALU_SUB; alu_a = dp_reg.t0; alu_b = dp_reg.ax; end
            S_Y_D:     begin alu_op = ALU_SUB; alu_a = dp_reg.rx; alu_b = dp_reg.t0; end
            S_Y_M:     begin alu_a = dp_reg.s; alu_b = dp_reg.t1; end
            S_Y_S:     begin alu_op = ALU_SUB; alu_a = dp_reg.t1; alu_b = dp_reg.ry; end
            default:   use_alu = 1'b0;
        endcase
        alu_ctrl.start = use_alu && !issued_reg;
        alu_ctrl.op    = alu_op;
        issued_next    = alu_done ? 1'b0 : (alu_ctrl.start ? 1'b1 : issued_reg);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:     if (s_acc) state_next = fp_low ? S_DONE : S_RED_PX;
            S_RED_PX:   if (alu_done) state_next = S_RED_PY;
            S_RED_PY:   if (alu_done) state_next = S_RED_QX;
            S_RED_QX:   if (alu_done) state_next = S_RED_QY;
            S_RED_QY:   if (alu_done) state_next = S_RED_A;
            S_RED_A:    if (alu_done) state_next = S_RED_B;
            S_RED_B:    if (alu_done) state_next = S_ONC_LHS;
            S_ONC_LHS:  if (alu_done) state_next = S_ONC_X2;
            S_ONC_X2:   if (alu_done) state_next = S_ONC_X3;
            S_ONC_X3:   if (alu_done) state_next = S_ONC_AX;
            S_ONC_AX:   if (alu_done) state_next = S_ONC_S1;
            S_ONC_S1:   if (alu_done) state_next = S_ONC_S2;
            S_ONC_S2:   if (alu_done) state_next = S_DISPATCH;
            S_DISPATCH: begin
                if (!dp_reg.is_mul) state_next = S_PA_CHK;
                else if (dp_reg.pinf || dp_reg.k == '0) state_next = S_DONE;
                else state_next = S_TOP;
            end
            S_TOP:      if (dp_reg.k[SB-1]) state_next = S_MUL_NEXT;
            S_MUL_NEXT: state_next = (dp_reg.cnt == '0) ? S_DONE : S_PA_CHK;
            S_PA_CHK: begin
                if (dp_reg.rinf || dp_reg.ainf) state_next = S_PA_END;
                else state_next = S_PA_NEG;
            end
            S_PA_NEG: begin
                if (alu_done) begin
                    if (dp_reg.rx == dp_reg.ax && dp_reg.ry == alu_res) state_next = S_PA_END;
                    else if (dp_reg.rx == dp_reg.ax && dp_reg.ry == dp_reg.ay)
                        state_next = S_DB_X2;
                    else state_next = S_AD_DY;
                end
            end
            S_PA_END: begin
                if (!dp_reg.is_mul) state_next = S_DONE;
                else if (dp_reg.dbl && dp_reg.k[SB-1]) state_next = S_PA_CHK;
                else state_next = S_MUL_NEXT;
            end
            S_DB_X2:    if (alu_done) state_next = S_DB_M3;
            S_DB_M3:    if (alu_done) state_next = S_DB_PA;
            S_DB_PA:    if (alu_done) state_next = S_DB_Y2;
            S_DB_Y2:    if (alu_done) state_next = S_INV_INIT;
            S_AD_DY:    if (alu_done) state_next = S_AD_DX;
            S_AD_DX:    if (alu_done) state_next = S_INV_INIT;
            S_INV_INIT: state_next = S_INV_CHK;
            S_INV_CHK: begin
                if (dp_reg.r1 != '0) state_next = S_INV_DIV;
                else if (dp_reg.r0 != FB'(1)) state_next = S_DONE;
                else state_next = S_SLOPE;
            end
            S_INV_DIV:  if (alu_done) state_next = S_INV_MUL;
            S_INV_MUL:  if (alu_done) state_next = S_INV_SUB;
            S_INV_SUB:  if (alu_done) state_next = S_INV_CHK;
            S_SLOPE:    if (alu_done) state_next = S_X_SS;
            S_X_SS:     if (alu_done) state_next = S_X_S1;
            S_X_S1:     if (alu_done) state_next = S_X_S2;
            S_X_S2:     if (alu_done) state_next = S_Y_D;
            S_Y_D:      if (alu_done) state_next = S_Y_M;
            S_Y_M:      if (alu_done) state_next = S_Y_S;
            S_Y_S:      if (alu_done) state_next = S_PA_END;
            S_DONE:     if (out_load) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // datapath updates
    always_comb begin
        dp_next = dp_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    dp_next.px     = s_p_x;
                    dp_next.py     = s_p_y;
                    dp_next.qx     = s_q_x;
                    dp_next.qy     = s_q_y;
                    dp_next.pinf   = s_p_is_infinity;
                    dp_next.qinf   = s_q_is_infinity;
                    dp_next.is_mul = (s_req_type == REQ_MUL);
                    dp_next.k      = s_scalar_k;
                    dp_next.cnt    = CW'(SB - 1);
                    dp_next.rinf   = 1'b1;
                    dp_next.onc    = 1'b0;
                    dp_next.bad    = fp_low;
                end
            end
            S_RED_PX:  if (alu_done) dp_next.px = alu_res;
            S_RED_PY:  if (alu_done) dp_next.py = alu_res;
            S_RED_QX:  if (alu_done) dp_next.qx = alu_res;
            S_RED_QY:  if (alu_done) dp_next.qy = alu_res;
            S_RED_A:   if (alu_done) dp_next.ar = alu_res;
            S_RED_B:   if (alu_done) dp_next.br = alu_res;
            S_ONC_LHS: if (alu_done) dp_next.t0 = alu_res;
            S_ONC_X2, S_ONC_X3, S_ONC_S1: if (alu_done) dp_next.t1 = alu_res;
            S_ONC_AX:  if (alu_done) dp_next.t2 = alu_res;
            S_ONC_S2:  if (alu_done) dp_next.onc = dp_reg.pinf || (dp_reg.t0 == alu_res);
            S_DISPATCH: begin
                if (!dp_reg.is_mul) begin
                    dp_next.rx   = dp_reg.px;
                    dp_next.ry   = dp_reg.py;
                    dp_next.rinf = dp_reg.pinf;
                    dp_next.ax   = dp_reg.qx;
                    dp_next.ay   = dp_reg.qy;
                    dp_next.ainf = dp_reg.qinf;
                end
            end
            S_TOP: begin
                dp_next.k = {dp_reg.k[SB-2:0], 1'b0};
                if (dp_reg.k[SB-1]) begin
                    dp_next.rx   = dp_reg.px;
                    dp_next.ry   = dp_reg.py;
                    dp_next.rinf = 1'b0;
                end else begin
                    dp_next.cnt = dp_reg.cnt - 1'b1;
                end
            end
            S_MUL_NEXT: begin
                dp_next.ax   = dp_reg.rx;
                dp_next.ay   = dp_reg.ry;
                dp_next.ainf = dp_reg.rinf;
                dp_next.dbl  = 1'b1;
            end
            S_PA_CHK: begin
                if (dp_reg.rinf) begin
                    dp_next.rx   = dp_reg.ax;
                    dp_next.ry   = dp_reg.ay;
                    dp_next.rinf = dp_reg.ainf;
                end
            end
            S_PA_NEG: begin
                if (alu_done && dp_reg.rx == dp_reg.ax && dp_reg.ry == alu_res)
                    dp_next.rinf = 1'b1;
            end
            S_PA_END: begin
                if (dp_reg.dbl && dp_reg.k[SB-1]) begin
                    dp_next.ax   = dp_reg.px;
                    dp_next.ay   = dp_reg.py;
                    dp_next.ainf = 1'b0;
                    dp_next.dbl  = 1'b0;
                end else begin
                    dp_next.k   = {dp_reg.k[SB-2:0], 1'b0};
                    dp_next.cnt = dp_reg.cnt - 1'b1;
                end
            end
            S_DB_X2, S_DB_M3, S_DB_PA, S_AD_DY: if (alu_done) dp_next.t1 = alu_res;
            S_DB_Y2, S_AD_DX: if (alu_done) dp_next.t2 = alu_res;
            S_INV_INIT: begin
                dp_next.r0 = fp_reg;
                dp_next.r1 = dp_reg.t2;
                dp_next.v0 = '0;
                dp_next.v1 = FB'(1);
            end
            S_INV_CHK: begin
                if (dp_reg.r1 == '0) begin
                    if (dp_reg.r0 != FB'(1)) dp_next.bad = 1'b1;
                    else dp_next.t2 = dp_reg.v0;
                end
            end
            S_INV_DIV: begin
                if (alu_done) begin
                    dp_next.qq = alu_quo;
                    dp_next.rm = alu_res;
                end
            end
            S_INV_MUL: if (alu_done) dp_next.t0 = alu_res;
            S_INV_SUB: begin
                if (alu_done) begin
                    dp_next.r0 = dp_reg.r1;
                    dp_next.r1 = dp_reg.rm;
                    dp_next.v0 = dp_reg.v1;
                    dp_next.v1 = alu_res;
                end
            end
            S_SLOPE:   if (alu_done) dp_next.s = alu_res;
            S_X_SS, S_X_S1, S_X_S2: if (alu_done) dp_next.t0 = alu_res;
            S_Y_D, S_Y_M: if (alu_done) dp_next.t1 = alu_res;
            S_Y_S: begin
                if (alu_done) begin
                    dp_next.ry   = alu_res;
                    dp_next.rx   = dp_reg.t0;
                    dp_next.rinf = 1'b0;
                end
            end
            default: dp_next = dp_reg;
        endcase
    end

    assign m_valid_next = out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            issued_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            fp_reg      <= FB'(FP_RESET);
            ca_reg      <= '0;
            cb_reg      <= '0;
        end else begin
            state_reg   <= state_next;
            issued_reg  <= issued_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_FIELD_PRIME: fp_reg <= cfg_data;
                    CFG_CURVE_A:     ca_reg <= cfg_data;
                    CFG_CURVE_B:     cb_reg <= cfg_data;
                    default:         ;
                endcase
            end
        end
        dp_reg <= dp_next;
        if (out_load) begin
            m_r_inf_reg <= dp_reg.bad || dp_reg.rinf;
            m_r_x_reg   <= (dp_reg.bad || dp_reg.rinf) ? '0 : dp_reg.rx;
            m_r_y_reg   <= (dp_reg.bad || dp_reg.rinf) ? '0 : dp_reg.ry;
            m_onc_reg   <= dp_reg.onc;
            m_bad_reg   <= dp_reg.bad;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_r_x            = m_r_x_reg;
    assign m_r_y            = m_r_y_reg;
    assign m_r_is_infinity  = m_r_inf_reg;
    assign m_p_on_curve     = m_onc_reg;
    assign m_inverse_failed = m_bad_reg;

endmodule

// File: sv/ecpa_checker.sv
// port-level checks for the elliptic-curve point unit, bound to the top level
// depends on ecpa_pkg and ec_point_add_and_scalar_multiply
module ecpa_checker import ecpa_pkg::*; #(
    parameter int FIELD_BITS = FIELD_BITS_DEF
) (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [FIELD_BITS-1:0] m_r_x,
    input logic [FIELD_BITS-1:0] m_r_y,
    input logic                  m_r_is_infinity,
    input logic                  m_inverse_failed
);

    // one item in flight: ready drops after an accept
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while an item is in flight");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_r_x) && $stable(m_r_y))
        else $error("stalled result changed");

    a_inf_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_r_is_infinity |-> m_r_x == '0 && m_r_y == '0)
        else $error("infinity result with nonzero coordinates");

    a_fail_inf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_inverse_failed |-> m_r_is_infinity)
        else $error("failed inversion without infinity result");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind ec_point_add_and_scalar_multiply ecpa_checker #(.FIELD_BITS(FIELD_BITS)) u_ecpa_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_r_x            (m_r_x),
    .m_r_y            (m_r_y),
    .m_r_is_infinity  (m_r_is_infinity),
    .m_inverse_failed (m_inverse_failed)
);

// File: dv/tb.sv
// self-checking testbench for ec_point_add_and_scalar_multiply: point add and k*P
// with a scoreboard class predicting every result; depends on ecpa_pkg and the rtl
`timescale 1ns / 1ps

module tb;
    import ecpa_pkg::*;

    localparam int WATCHDOG_LIMIT = 400000;
    localparam int NUM_PHASES     = 6;
    localparam int RAND_PER_PHASE = 50;

    typedef struct {
        logic        req;
        logic [15:0] px, py, qx, qy, k;
        logic        pinf, qinf;
    } ec_item_t;

    typedef struct {
        logic [15:0] rx, ry;
        logic        rinf, onc, ifail;
    } ec_res_t;

    typedef struct {
        longint unsigned x, y;
        bit              inf;
    } ec_pt_t;

    class point_scoreboard;
        logic [15:0]     prime, ca, cb;
        longint unsigned md;
        bit              inv_bad;
        ec_res_t         pending[$];
        int              errors;

        function new();
            prime = 16'(FP_RESET);
            ca = '0;
            cb = '0;
            md = FP_RESET;
            errors = 0;
        endfunction

        function longint unsigned fadd(longint unsigned u, longint unsigned v);
            return (u + v) % md;
        endfunction
        function longint unsigned fsub(longint unsigned u, longint unsigned v);
            return (u + md - v) % md;
        endfunction
        function longint unsigned fmul(longint unsigned u, longint unsigned v);
            return (u * v) % md;
        endfunction

        function longint unsigned finv(longint unsigned v);
            longint r0, r1, t0, t1, q, rt, tt;
            r0 = md;
            r1 = v % md;
            t0 = 0;
            t1 = 1;
            while (r1 != 0) begin
                q = r0 / r1;
                rt = r0 - q * r1;
                tt = t0 - q * t1;
                r0 = r1; r1 = rt;
                t0 = t1; t1 = tt;
            end
            if (r0 != 1) begin
                inv_bad = 1;
                return 0;
            end
            if (t0 < 0) t0 += md;
            return longint'(t0) % md;
        endfunction

        function ec_pt_t padd(ec_pt_t a, ec_pt_t b);
            ec_pt_t r;
            longint unsigned s, num, x3;
            r.x = 0; r.y = 0; r.inf = 1;
            if (inv_bad) return r;
            if (a.inf) return b;
            if (b.inf) return a;
            if (a.x == b.x && a.y == fsub(0, b.y)) return r;
            if (a.x == b.x && a.y == b.y) begin
                num = fadd(fmul(3, fmul(a.x, a.x)), ca % md);
                s = fmul(num, finv(fadd(a.y, a.y)));
            end else begin
                s = fmul(fsub(a.y, b.y), finv(fsub(a.x, b.x)));
            end
            if (inv_bad) return r;
            x3 = fsub(fsub(fmul(s, s), a.x), b.x);
            r.x = x3;
            r.y = fsub(fmul(s, fsub(a.x, x3)), a.y);
            r.inf = 0;
            return r;
        endfunction

        function ec_pt_t pmul(logic [15:0] k, ec_pt_t p);
            ec_pt_t r;
            int top;
            r.x = 0; r.y = 0; r.inf = 1;
            top = -1;
            if (p.inf) return r;
            for (int i = 15; i >= 0; i--)
                if (k[i] && top < 0) top = i;
            if (top < 0) return r;
            r = p;
            for (int i = top - 1; i >= 0 && !inv_bad; i--) begin
                r = padd(r, r);
                if (k[i]) r = padd(r, p);
            end
            return r;
        endfunction

        function ec_res_t compute(ec_item_t it);
            ec_res_t e;
            ec_pt_t p, q, r;
            longint unsigned lhs, rhs;
            inv_bad = 0;
            if (prime < 2) begin
                e.rx = 0; e.ry = 0; e.rinf = 1; e.onc = 0; e.ifail = 1;
                return e;
            end
            md = prime;
            p.x = it.px % md; p.y = it.py % md; p.inf = it.pinf;
            q.x = it.qx % md; q.y = it.qy % md; q.inf = it.qinf;
            if (p.inf) e.onc = 1;
            else begin
                lhs = fmul(p.y, p.y);
                rhs = fadd(fadd(fmul(fmul(p.x, p.x), p.x), fmul(ca % md, p.x)), cb % md);
                e.onc = (lhs == rhs);
            end
            r = (it.req == REQ_MUL) ? pmul(it.k, p) : padd(p, q);
            if (inv_bad || r.inf) begin
                r.x = 0; r.y = 0; r.inf = 1;
            end
            e.rx = r.x[15:0];
            e.ry = r.y[15:0];
            e.rinf = r.inf;
            e.ifail = inv_bad;
            return e;
        endfunction

        function void note(ec_item_t it);
            pending.push_back(compute(it));
        endfunction

        function void check(ec_res_t got);
            ec_res_t e;
            if (pending.size() == 0) begin
                $error("result with no item outstanding");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.rx !== e.rx) begin
                $error("r_x expected %0d actual %0d", e.rx, got.rx); errors++;
            end
            if (got.ry !== e.ry) begin
                $error("r_y expected %0d actual %0d", e.ry, got.ry); errors++;
            end
            if (got.rinf !== e.rinf) begin
                $error("r_is_infinity expected %0d actual %0d", e.rinf, got.rinf); errors++;
            end
            if (got.onc !== e.onc) begin
                $error("p_on_curve expected %0d actual %0d", e.onc, got.onc); errors++;
            end
            if (got.ifail !== e.ifail) begin
                $error("inverse_failed expected %0d actual %0d", e.ifail, got.ifail);
                errors++;
            end
        endfunction
    endclass

    logic                    aclk, aresetn;
    logic                    s_valid, s_ready, s_req_type, s_p_is_infinity, s_q_is_infinity;
    logic [15:0]             s_p_x, s_p_y, s_q_x, s_q_y, s_scalar_k;
    logic                    m_valid, m_ready, m_r_is_infinity, m_p_on_curve, m_inverse_failed;
    logic [15:0]             m_r_x, m_r_y;
    logic                    cfg_valid, cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [15:0]             cfg_data;

    point_scoreboard sb;
    int              send_idle, recv_idle, idle_cycles;
    ec_pt_t          gen_pt;

    ec_point_add_and_scalar_multiply dut (.*);

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        m_ready = 0;
        forever begin
            @(negedge aclk);
            m_ready = ($urandom_range(0, 99) >= recv_idle);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note('{s_req_type, s_p_x, s_p_y, s_q_x, s_q_y, s_scalar_k,
                          s_p_is_infinity, s_q_is_infinity});
            if (m_valid && m_ready)
                sb.check('{m_r_x, m_r_y, m_r_is_infinity, m_p_on_curve, m_inverse_failed});
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [15:0] val);
        cfg_valid = 1;
        cfg_index = idx;
        cfg_data = val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_FIELD_PRIME: sb.prime = val;
            CFG_CURVE_A:     sb.ca = val;
            default:         sb.cb = val;
        endcase
        @(negedge aclk);
        cfg_valid = 0;
    endtask

    task automatic send_item(ec_item_t it);
        while ($urandom_range(0, 99) < send_idle) @(negedge aclk);
        s_valid = 1;
        s_req_type = it.req;
        s_p_x = it.px; s_p_y = it.py; s_p_is_infinity = it.pinf;
        s_q_x = it.qx; s_q_y = it.qy; s_q_is_infinity = it.qinf;
        s_scalar_k = it.k;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        s_valid = 0;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    function automatic ec_pt_t curve_pt();
        logic [15:0] k;
        k = 16'($urandom_range(1, 40));
        sb.inv_bad = 0;
        sb.md = (sb.prime < 2) ? 2 : sb.prime;
        return sb.pmul(k, gen_pt);
    endfunction

    function automatic ec_item_t mk(logic req, ec_pt_t p, ec_pt_t q, logic [15:0] k);
        return '{req, p.x[15:0], p.y[15:0], q.x[15:0], q.y[15:0], k, p.inf, q.inf};
    endfunction

    task automatic directed_items();
        ec_pt_t p, q, z;
        p = gen_pt;
        q = curve_pt();
        z = '{0, 0, 1};
        send_item(mk(REQ_ADD, p, q, 16'hffff));
        send_item(mk(REQ_ADD, z, q, 0));
        send_item(mk(REQ_ADD, p, z, 0));
        send_item(mk(REQ_ADD, z, z, 0));
        send_item(mk(REQ_ADD, p, p, 0));
        send_item(mk(REQ_ADD, p, '{p.x, (sb.prime - p.y) % sb.prime, 0}, 0));
        send_item(mk(REQ_ADD, '{5, 0, 0}, '{5, 0, 0}, 0));
        send_item(mk(REQ_ADD, '{p.x + sb.prime, p.y, 0}, '{q.x, q.y + sb.prime, 0}, 0));
        send_item(mk(REQ_ADD, '{16'hffff, 16'hffff, 0}, '{0, 0, 0}, 0));
        send_item(mk(REQ_ADD, '{16'hffff, 16'hffff, 1}, '{16'hffff, 16'hffff, 1}, 0));
        send_item(mk(REQ_MUL, p, q, 0));
        send_item(mk(REQ_MUL, p, q, 1));
        send_item(mk(REQ_MUL, p, q, 2));
        send_item(mk(REQ_MUL, p, q, 3));
        send_item(mk(REQ_MUL, p, q, 16'h8000));
        send_item(mk(REQ_MUL, p, z, 16'hffff));
        send_item(mk(REQ_MUL, z, q, 16'hffff));
        send_item(mk(REQ_MUL, '{1, 2, 0}, q, 5));
        send_item(mk(REQ_MUL, '{5, 0, 0}, q, 2));
        send_item(mk(REQ_ADD, '{3, 3, 0}, '{16'hfff0, 16'h0001, 0}, 16'h5a5a));
    endtask

    function automatic logic [15:0] rand_scalar();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 16'($urandom);
        if (r < 15) return 16'($urandom_range(0, 1));
        return 16'($urandom_range(2, 31));
    endfunction

    task automatic random_items(int n, bit hold_off);
        ec_item_t it;
        ec_pt_t p, q;
        for (int i = 0; i < n; i++) begin
            if (hold_off && i == n / 2) drain();
            p = curve_pt();
            q = curve_pt();
            case ($urandom_range(0, 9))
                0: p.inf = 1;
                1: q.inf = 1;
                2: q = p;
                3: q = '{p.x, (sb.prime - p.y) % sb.prime, p.inf};
                default: ;
            endcase
            it = mk(1'($urandom_range(0, 1)), p, q, rand_scalar());
            if ($urandom_range(0, 4) == 0) begin
                it.px = 16'($urandom); it.py = 16'($urandom);
                it.qx = 16'($urandom); it.qy = 16'($urandom);
                it.pinf = 1'($urandom_range(0, 1)); it.qinf = 1'($urandom_range(0, 1));
            end
            send_item(it);
        end
    endtask

    initial begin
        logic [15:0] primes[NUM_PHASES] = '{16'd65521, 16'd3, 16'd65535, 16'd251,
                                             16'd1009, 16'd65521};
        logic [15:0] acoef[NUM_PHASES] = '{16'd0, 16'd2, 16'd65535, 16'd7,
                                            16'd0, 16'd65535};
        longint unsigned bval;
        sb = new();
        aresetn = 0;
        s_valid = 0; s_req_type = 0; s_p_x = 0; s_p_y = 0; s_p_is_infinity = 0;
        s_q_x = 0; s_q_y = 0; s_q_is_infinity = 0; s_scalar_k = 0;
        cfg_valid = 0; cfg_index = CFG_FIELD_PRIME; cfg_data = 0;
        send_idle = 28; recv_idle = 46; idle_cycles = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph < 2) begin
                send_idle = 28; recv_idle = 46;
            end else if (ph < 4) begin
                send_idle = 46; recv_idle = 28;
            end else begin
                send_idle = 0; recv_idle = 0;
            end
            drain();
            write_reg(CFG_FIELD_PRIME, primes[ph]);
            write_reg(CFG_CURVE_A, acoef[ph]);
            sb.md = primes[ph];
            gen_pt.x = $urandom_range(0, primes[ph] - 1);
            gen_pt.y = $urandom_range(0, primes[ph] - 1);
            gen_pt.inf = 0;
            bval = sb.fsub(sb.fsub(sb.fmul(gen_pt.y, gen_pt.y),
                                   sb.fmul(sb.fmul(gen_pt.x, gen_pt.x), gen_pt.x)),
                           sb.fmul(acoef[ph] % sb.md, gen_pt.x));
            if (ph == 4) bval += primes[ph];
            write_reg(CFG_CURVE_B, bval[15:0]);
            if (ph == 0) directed_items();
            random_items(RAND_PER_PHASE, ph == 1);
        end
        drain();
        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
